// ===== hdl/fsg_pkg.sv =====
// Package for the fault-step sine generator: widths, register indexes, reset
// values and the quarter-wave sine function evaluated at elaboration.
// No dependencies.
package fsg_pkg;

  // Default build parameters.
  localparam int FRAME_LEN_DEF  = 20;
  localparam int TABLE_BITS_DEF = 10;

  // Field and register widths.
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int PHASE_W  = 32;
  localparam int INDEX_W  = 32;
  localparam int MAG_W    = 16;
  localparam int SINE_W   = 24;
  localparam int SAMPLE_W = 32;
  localparam int PROD_W   = MAG_W + SINE_W;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAULT_SAMPLE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAGNITUDE_BEFORE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_BEFORE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAGNITUDE_AFTER  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_AFTER      = 3'd5;

  // Register values after reset.
  localparam logic [PHASE_W-1:0] RST_PHASE_STEP       = 32'd53687091;
  localparam logic [INDEX_W-1:0] RST_FAULT_SAMPLE     = 32'd8000;
  localparam logic [MAG_W-1:0]   RST_MAGNITUDE_BEFORE = 16'd2560;
  localparam logic [PHASE_W-1:0] RST_PHASE_BEFORE     = 32'd0;
  localparam logic [MAG_W-1:0]   RST_MAGNITUDE_AFTER  = 16'd25600;
  localparam logic [PHASE_W-1:0] RST_PHASE_AFTER      = 32'd0;

  // Pi/2 in Q30.
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1 << 30;
  localparam longint unsigned ONE_Q23     = 64'd1 << 23;

  typedef logic [SINE_W-1:0] sine_t;

  // Quarter-wave entry k of a table with 2^qbits steps per quarter, in Q1.23.
  // Odd Taylor series up to x^15, each term derived from the previous one.
  function automatic sine_t sine_entry(input int k, input int qbits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint          acc;
    longint unsigned r;
    x   = (PI_HALF_Q30 * longint'(k)) >> qbits;
    x2  = (x * x) >> 30;
    t   = x;
    acc = longint'(t);
    t   = ((t * x2) >> 30) / 6;
    acc = acc - longint'(t);
    t   = ((t * x2) >> 30) / 20;
    acc = acc + longint'(t);
    t   = ((t * x2) >> 30) / 42;
    acc = acc - longint'(t);
    t   = ((t * x2) >> 30) / 72;
    acc = acc + longint'(t);
    t   = ((t * x2) >> 30) / 110;
    acc = acc - longint'(t);
    t   = ((t * x2) >> 30) / 156;
    acc = acc + longint'(t);
    t   = ((t * x2) >> 30) / 210;
    acc = acc - longint'(t);
    if (acc < 0) acc = 0;
    if (acc > longint'(ONE_Q30)) acc = longint'(ONE_Q30);
    r = (longint'(acc) + 64) >> 7;
    if (r > ONE_Q23) r = ONE_Q23;
    return SINE_W'(r);
  endfunction

endpackage

// ===== hdl/fault_step_sine_generator.sv =====
// Each accepted frame request with frame_request set produces FRAME_LEN samples, one per
// cycle while the output is not stalled, the last one flagged by last_in_frame; a request
// with frame_request clear produces nothing. The next request is taken in the cycle that
// issues the last sample of a frame, so frames follow without a gap. The four-stage
// pipeline (phase and fault select, sine ROM read, multiply, round and sign) holds while
// a valid sample waits with out_ready low, and a request is still taken then if the
// generator is idle.
// Depends on fsg_pkg and fsg_sine_rom.
module fault_step_sine_generator #(
  parameter int FRAME_LEN  = fsg_pkg::FRAME_LEN_DEF,
  parameter int TABLE_BITS = fsg_pkg::TABLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration write port.
  input  logic                          cfg_we,
  input  logic [fsg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fsg_pkg::CFG_W-1:0]     cfg_data,
  // Request channel.
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          frame_request,
  // Sample channel.
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [fsg_pkg::SAMPLE_W-1:0] sample,
  output logic                          after_fault,
  output logic                          last_in_frame
);
  import fsg_pkg::*;

  localparam int CNT_W = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_LEN - 1);
  localparam int POS_W = TABLE_BITS - 1;
  localparam int K_W   = TABLE_BITS - 2;
  localparam logic [POS_W-1:0] QUARTER = POS_W'(1) << K_W;

  // Configuration registers.
  logic [PHASE_W-1:0] phase_step;
  logic [INDEX_W-1:0] fault_sample;
  logic [MAG_W-1:0]   magnitude_before;
  logic [PHASE_W-1:0] phase_before;
  logic [MAG_W-1:0]   magnitude_after;
  logic [PHASE_W-1:0] phase_after;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step       <= RST_PHASE_STEP;
      fault_sample     <= RST_FAULT_SAMPLE;
      magnitude_before <= RST_MAGNITUDE_BEFORE;
      phase_before     <= RST_PHASE_BEFORE;
      magnitude_after  <= RST_MAGNITUDE_AFTER;
      phase_after      <= RST_PHASE_AFTER;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PHASE_STEP:       phase_step       <= cfg_data[PHASE_W-1:0];
        REG_FAULT_SAMPLE:     fault_sample     <= cfg_data[INDEX_W-1:0];
        REG_MAGNITUDE_BEFORE: magnitude_before <= cfg_data[MAG_W-1:0];
        REG_PHASE_BEFORE:     phase_before     <= cfg_data[PHASE_W-1:0];
        REG_MAGNITUDE_AFTER:  magnitude_after  <= cfg_data[MAG_W-1:0];
        REG_PHASE_AFTER:      phase_after      <= cfg_data[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: the output register is empty or being taken.
  logic en;
  assign en = !out_valid || out_ready;

  // Generator state.
  logic               active;
  logic [CNT_W-1:0]   cnt;
  logic [INDEX_W-1:0] sample_index;
  logic [PHASE_W-1:0] phase_acc;
  logic               issue;
  logic               in_xfer;

  assign issue    = active && en;
  assign in_ready = !active || (en && cnt == CNT_LAST);
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      cnt          <= '0;
      sample_index <= '0;
      phase_acc    <= '0;
    end else begin
      if (issue) begin
        phase_acc <= phase_acc + phase_step;
        if (sample_index != '1) begin
          sample_index <= sample_index + INDEX_W'(1);
        end
        if (cnt == CNT_LAST) begin
          cnt    <= '0;
          active <= 1'b0;
        end else begin
          cnt <= cnt + CNT_W'(1);
        end
      end
      // A transfer with the request bit set starts a new frame.
      if (in_xfer && frame_request) begin
        active <= 1'b1;
        cnt    <= '0;
      end
    end
  end

  // Stage A: fault select and phase sum.
  logic               a_valid;
  logic [PHASE_W-1:0] a_phase;
  logic               a_after;
  logic [MAG_W-1:0]   a_mag;
  logic               a_last;
  logic               gen_after;

  assign gen_after = sample_index >= fault_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= active;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_phase <= phase_acc + (gen_after ? phase_after : phase_before);
      a_after <= gen_after;
      a_mag   <= gen_after ? magnitude_after : magnitude_before;
      a_last  <= (cnt == CNT_LAST);
    end
  end

  // Stage B: quadrant fold and sine ROM read.
  logic [TABLE_BITS-1:0] tab_idx;
  logic [K_W-1:0]        tab_k;
  logic [POS_W-1:0]      tab_pos;
  logic                  b_valid;
  logic                  b_neg;
  logic                  b_after;
  logic [MAG_W-1:0]      b_mag;
  logic                  b_last;
  sine_t                 b_sine;

  assign tab_idx = a_phase[PHASE_W-1 -: TABLE_BITS];
  assign tab_k   = tab_idx[K_W-1:0];
  assign tab_pos = tab_idx[K_W] ? (QUARTER - {1'b0, tab_k}) : {1'b0, tab_k};

  fsg_sine_rom #(
    .TABLE_BITS(TABLE_BITS)
  ) u_rom (
    .clk (clk),
    .en  (en),
    .addr(tab_pos),
    .data(b_sine)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_neg   <= tab_idx[TABLE_BITS-1];
      b_after <= a_after;
      b_mag   <= a_mag;
      b_last  <= a_last;
    end
  end

  // Stage C: magnitude times sine.
  logic              c_valid;
  logic [PROD_W-1:0] c_prod;
  logic              c_neg;
  logic              c_after;
  logic              c_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_prod  <= PROD_W'(b_mag) * PROD_W'(b_sine);
      c_neg   <= b_neg;
      c_after <= b_after;
      c_last  <= b_last;
    end
  end

  // Output register: round half up, drop eight fraction bits, apply sign.
  logic [PROD_W-1:0]   rounded;
  logic [SAMPLE_W-1:0] mag_val;

  assign rounded = (c_prod + PROD_W'(128)) >> 8;
  assign mag_val = rounded[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sample        <= c_neg ? -$signed(mag_val) : $signed(mag_val);
      after_fault   <= c_after;
      last_in_frame <= c_last;
    end
  end

endmodule

// ===== hdl/fsg_sine_rom.sv =====
// Quarter-wave sine ROM with a registered read port.
// Depends on fsg_pkg for the entry function and widths.
module fsg_sine_rom #(
  parameter int TABLE_BITS = fsg_pkg::TABLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [TABLE_BITS-2:0]   addr,
  output logic [fsg_pkg::SINE_W-1:0] data
);
  import fsg_pkg::*;

  localparam int QUARTER_LEN = 1 << (TABLE_BITS - 2);

  // Table contents are fixed at elaboration.
  sine_t rom [QUARTER_LEN+1];

  for (genvar g = 0; g <= QUARTER_LEN; g++) begin : g_rom
    assign rom[g] = sine_entry(g, TABLE_BITS - 2);
  end

  // Registered read; the address never exceeds the quarter length.
  always_ff @(posedge clk) begin
    if (en) begin
      data <= rom[addr];
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for fault_step_sine_generator: random request and sample
// handshakes, a local DDS predictor and a per-field compare of every sample.
// Depends on fsg_pkg and the generator RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fsg_pkg::*;

  localparam int FRAME_SIZE    = FRAME_LEN_DEF;
  localparam int TABLE_SIZE    = TABLE_BITS_DEF;
  localparam int QUARTER_STEPS = 1 << (TABLE_SIZE - 2);
  localparam longint unsigned HALF_TURN_Q30 = 64'd1686629713;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 7;
  localparam int FRAMES_PER_PHASE = 56;

  // Register indexes the block does not decode.
  localparam logic [CFG_IDX_W-1:0] SPARE_REG_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] SPARE_REG_HI = 3'd7;

  typedef struct {
    logic signed [SAMPLE_W-1:0] value;
    logic                       after_fault;
    logic                       last_in_frame;
  } sample_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic frame_request = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] sample;
  logic after_fault;
  logic last_in_frame;

  // Bench control shared between processes.
  bit pending_requests[$];
  sample_word_t expected_samples[$];
  int requests_queued = 0;
  int requests_taken = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  logic steady = 1'b0;
  int hold_asks = 0;
  int holds_served = 0;
  int hold_left = 0;

  // Predictor state: quarter-wave table, registers and generator state.
  logic [SINE_W-1:0] quarter_sine [0:QUARTER_STEPS];
  logic [PHASE_W-1:0] tone_step;
  logic [INDEX_W-1:0] fault_at;
  logic [MAG_W-1:0]   gain_pre;
  logic [PHASE_W-1:0] offset_pre;
  logic [MAG_W-1:0]   gain_post;
  logic [PHASE_W-1:0] offset_post;
  logic [INDEX_W-1:0] next_index;
  logic [PHASE_W-1:0] phase_acc;

  fault_step_sine_generator dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .frame_request(frame_request),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sample(sample),
    .after_fault(after_fault),
    .last_in_frame(last_in_frame)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Quarter-wave entry in Q1.23 from a Taylor series in Q30.
  function automatic logic [SINE_W-1:0] quarter_wave_entry(int k);
    longint unsigned angle;
    longint unsigned angle_sq;
    longint unsigned term;
    longint unsigned rounded;
    longint total;
    angle = (HALF_TURN_Q30 * longint'(k)) / QUARTER_STEPS;
    angle_sq = (angle * angle) >> 30;
    term = angle;
    total = 0;
    for (int n = 1; n <= 15; n += 2) begin
      if ((n % 4) == 1) begin
        total = total + longint'(term);
      end else begin
        total = total - longint'(term);
      end
      term = ((term * angle_sq) >> 30) / longint'((n + 1) * (n + 2));
    end
    if (total < 0) total = 0;
    if (total > (longint'(1) << 30)) total = longint'(1) << 30;
    rounded = (longint'(total) + 64) >> 7;
    if (rounded > (64'd1 << 23)) rounded = 64'd1 << 23;
    return rounded[SINE_W-1:0];
  endfunction

  // Register write as the block sees it; narrow registers keep the low bits.
  function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    case (idx)
      REG_PHASE_STEP:       tone_step = value;
      REG_FAULT_SAMPLE:     fault_at = value;
      REG_MAGNITUDE_BEFORE: gain_pre = value[MAG_W-1:0];
      REG_PHASE_BEFORE:     offset_pre = value;
      REG_MAGNITUDE_AFTER:  gain_post = value[MAG_W-1:0];
      REG_PHASE_AFTER:      offset_post = value;
      default: ;
    endcase
  endfunction

  // Expected samples of one frame; advances the phase and the saturating index.
  function automatic void predict_frame();
    sample_word_t want;
    logic past_fault;
    logic [MAG_W-1:0] gain;
    logic [PHASE_W-1:0] angle;
    logic [TABLE_SIZE-1:0] slot;
    logic [1:0] quadrant;
    int pos;
    longint unsigned scaled;
    logic [SAMPLE_W-1:0] level;
    for (int n = 0; n < FRAME_SIZE; n++) begin
      past_fault = (next_index >= fault_at);
      gain = past_fault ? gain_post : gain_pre;
      angle = phase_acc + (past_fault ? offset_post : offset_pre);
      slot = angle[PHASE_W-1 -: TABLE_SIZE];
      quadrant = slot[TABLE_SIZE-1 -: 2];
      pos = int'(slot[TABLE_SIZE-3:0]);
      if (quadrant[0]) pos = QUARTER_STEPS - pos;
      scaled = ((64'(gain) * 64'(quarter_sine[pos])) + 64'd128) >> 8;
      level = scaled[SAMPLE_W-1:0];
      if (quadrant[1]) level = -level;
      want.value = level;
      want.after_fault = past_fault;
      want.last_in_frame = (n == FRAME_SIZE - 1);
      expected_samples.push_back(want);
      phase_acc = phase_acc + tone_step;
      if (next_index != '1) next_index = next_index + 1'b1;
    end
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Compare one sample transfer against the oldest expectation.
  task automatic check_sample();
    sample_word_t want;
    if (expected_samples.size() == 0) begin
      report_mismatch($sformatf("sample %0d with nothing expected", sample));
    end else begin
      want = expected_samples.pop_front();
      if (sample !== want.value)
        report_mismatch($sformatf("sample %0d, want %0d", sample, want.value));
      if (after_fault !== want.after_fault)
        report_mismatch($sformatf("after_fault %b, want %b", after_fault, want.after_fault));
      if (last_in_frame !== want.last_in_frame)
        report_mismatch($sformatf("last_in_frame %b, want %b", last_in_frame,
                                  want.last_in_frame));
    end
  endtask

  // Request driver: holds each item until its transfer, idles at random.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_requests.size() != 0 && (steady || $urandom_range(99) >= 11)) begin
        in_valid <= 1'b1;
        frame_request <= pending_requests.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Sample receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_asks != holds_served) begin
      holds_served = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 11);
    end
  end

  // Monitor: checks sample transfers, predicts on request transfers.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) check_sample();
      if (in_valid && in_ready) begin
        if (frame_request) predict_frame();
        requests_taken++;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fault_step_sine_generator test failed");
      $finish;
    end
  end

  task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    apply_setting(idx, value);
  endtask

  task automatic close_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_request(bit req);
    pending_requests.push_back(req);
    requests_queued++;
  endtask

  // Random requests until the given number of frames is queued.
  task automatic queue_frames(int frames, int zero_pct);
    int frames_queued;
    frames_queued = 0;
    while (frames_queued < frames) begin
      if ($urandom_range(99) < zero_pct) begin
        push_request(1'b0);
      end else begin
        push_request(1'b1);
        frames_queued++;
      end
    end
  endtask

  // Wait until every request is taken and every sample has come back.
  task automatic wait_quiet();
    do @(posedge clk);
    while (requests_taken != requests_queued || expected_samples.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic pick_random_settings();
    logic [PHASE_W-1:0] step;
    logic [INDEX_W-1:0] fault;
    case ($urandom_range(2))
      0: step = $urandom();
      1: step = $urandom_range(32'h0100_0000);
      default: step = $urandom_range(255) << 24;
    endcase
    case ($urandom_range(3))
      0: fault = $urandom();
      1: fault = '0;
      default: fault = next_index + $urandom_range(FRAMES_PER_PHASE * FRAME_SIZE);
    endcase
    set_register(REG_PHASE_STEP, step);
    set_register(REG_FAULT_SAMPLE, fault);
    set_register(REG_MAGNITUDE_BEFORE, $urandom());
    set_register(REG_PHASE_BEFORE, $urandom());
    set_register(REG_MAGNITUDE_AFTER, $urandom());
    set_register(REG_PHASE_AFTER, $urandom());
    if ($urandom_range(2) == 0) set_register(CFG_IDX_W'($urandom_range(7)), $urandom());
    close_writes();
  endtask

  // Stimulus sequence.
  initial begin
    for (int k = 0; k <= QUARTER_STEPS; k++) quarter_sine[k] = quarter_wave_entry(k);
    tone_step = RST_PHASE_STEP;
    fault_at = RST_FAULT_SAMPLE;
    gain_pre = RST_MAGNITUDE_BEFORE;
    offset_pre = RST_PHASE_BEFORE;
    gain_post = RST_MAGNITUDE_AFTER;
    offset_post = RST_PHASE_AFTER;
    next_index = '0;
    phase_acc = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset settings, with zero requests mixed in.
    push_request(1'b1);
    push_request(1'b0);
    push_request(1'b1);
    push_request(1'b0);
    push_request(1'b1);
    wait_quiet();

    // Frozen phase, fault switch inside a frame, full and zero gain, wide
    // data on the 16-bit registers, writes to undecoded indexes.
    set_register(REG_PHASE_STEP, '0);
    set_register(REG_FAULT_SAMPLE, next_index + 7);
    set_register(REG_MAGNITUDE_BEFORE, 32'hABCD_FFFF);
    set_register(REG_PHASE_BEFORE, '1);
    set_register(REG_MAGNITUDE_AFTER, 32'hFFFF_0000);
    set_register(REG_PHASE_AFTER, 32'h8000_0000);
    set_register(SPARE_REG_LO, '1);
    set_register(SPARE_REG_HI, '1);
    close_writes();
    push_request(1'b1);
    push_request(1'b1);
    push_request(1'b0);
    push_request(1'b1);
    wait_quiet();

    // Largest step wraps the phase every sample; fault from index zero on.
    set_register(REG_PHASE_STEP, '1);
    set_register(REG_FAULT_SAMPLE, '0);
    set_register(REG_MAGNITUDE_AFTER, 32'h0000_FFFF);
    set_register(REG_PHASE_AFTER, 32'h4000_0000);
    set_register(REG_MAGNITUDE_BEFORE, '0);
    set_register(REG_PHASE_BEFORE, '0);
    close_writes();
    repeat (3) push_request(1'b1);
    wait_quiet();

    // Unit gain walking all four quadrants; no fault.
    set_register(REG_PHASE_STEP, 32'h0200_0000);
    set_register(REG_FAULT_SAMPLE, '1);
    set_register(REG_MAGNITUDE_BEFORE, 32'h0000_0100);
    set_register(REG_PHASE_BEFORE, '0);
    close_writes();
    repeat (8) push_request(1'b1);
    wait_quiet();

    // Random settings and requests; one phase without idling, one with a
    // long receiver hold-off while requests keep coming.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      pick_random_settings();
      steady <= (p == 2);
      if (p == 4) hold_asks <= hold_asks + 1;
      queue_frames(FRAMES_PER_PHASE, 10);
      wait_quiet();
    end

    if (mismatch_count == 0) begin
      $display("fault_step_sine_generator test passed");
    end else begin
      $display("fault_step_sine_generator test failed");
    end
    $finish;
  end

endmodule
